### hdl/mkd_pkg.sv
// Shared types and constants for the multi-key debounce block.
package mkd_pkg;

  // Number of pin bits carried by one scan item.
  localparam int unsigned PIN_BITS = 8;
  // Number of keys reported in the packed status field.
  localparam int unsigned PACKED_KEYS = 8;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX   = 16'hFFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 5'd31;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_PRESS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STUCK   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNSTUCK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HOLDOFF = 3'd4;

  // Reset values of the registers.
  localparam logic [CNT_W-1:0]  PRESS_RST   = 16'd5;
  localparam logic [CNT_W-1:0]  RELEASE_RST = 16'd5;
  localparam logic [CNT_W-1:0]  STUCK_RST   = 16'd6000;
  localparam logic [CNT_W-1:0]  UNSTUCK_RST = 16'd200;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST = 8'd10;

  // Reported status codes.
  localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
  localparam logic [1:0] CODE_RELEASED = 2'd1;
  localparam logic [1:0] CODE_PRESSED  = 2'd2;
  localparam logic [1:0] CODE_STUCK    = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  press_ticks;
    logic [CNT_W-1:0]  release_ticks;
    logic [CNT_W-1:0]  stuck_ticks;
    logic [CNT_W-1:0]  unstuck_ticks;
    logic [HOLD_W-1:0] holdoff_ticks;
  } cfg_t;

  // What one key lane reports to the merge stage on a tick.
  typedef struct packed {
    logic to_stuck;
    logic recover;
  } lane_evt_t;

endpackage

### hdl/mkd_lane.sv
// One key lane: debounce state machine with press, release and hold-off counters.
module mkd_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  mkd_pkg::cfg_t              cfg,
  input  logic                       tick,
  input  logic                       high,
  output logic [1:0]                 code_next,
  output mkd_pkg::lane_evt_t         evt
);

  typedef enum logic [3:0] {
    ST_UNKNOWN  = 4'b0001,
    ST_RELEASED = 4'b0010,
    ST_PRESSED  = 4'b0100,
    ST_STUCK    = 4'b1000
  } key_state_t;

  key_state_t                     state, state_next;
  logic [mkd_pkg::CNT_W-1:0]      press_cnt, press_cnt_next;
  logic [mkd_pkg::CNT_W-1:0]      rel_cnt, rel_cnt_next;
  logic [mkd_pkg::HOLD_W-1:0]     hold_cnt, hold_cnt_next;
  logic [mkd_pkg::CNT_W-1:0]      press_inc, rel_inc;

  // Saturating increments.
  assign press_inc = (press_cnt == mkd_pkg::CNT_MAX) ? press_cnt : press_cnt + 1'b1;
  assign rel_inc   = (rel_cnt == mkd_pkg::CNT_MAX) ? rel_cnt : rel_cnt + 1'b1;

  always_comb begin
    state_next     = state;
    press_cnt_next = press_cnt;
    rel_cnt_next   = rel_cnt;
    hold_cnt_next  = hold_cnt;
    evt            = '0;
    if (hold_cnt != '0) begin
      hold_cnt_next = hold_cnt - 1'b1;
    end else begin
      unique case (state)
        ST_RELEASED: begin
          if (high) begin
            press_cnt_next = '0;
          end else begin
            press_cnt_next = press_inc;
            if (press_inc >= cfg.press_ticks) begin
              state_next    = ST_PRESSED;
              hold_cnt_next = cfg.holdoff_ticks;
            end
          end
        end
        ST_PRESSED: begin
          if (high) begin
            rel_cnt_next = rel_inc;
            if (rel_inc > cfg.release_ticks) begin
              rel_cnt_next   = '0;
              press_cnt_next = '0;
              state_next     = ST_RELEASED;
              hold_cnt_next  = cfg.holdoff_ticks;
            end
          end else begin
            rel_cnt_next   = '0;
            press_cnt_next = press_inc;
            if (press_inc > cfg.stuck_ticks) begin
              state_next     = ST_STUCK;
              press_cnt_next = '0;
              evt.to_stuck   = 1'b1;
            end
          end
        end
        ST_UNKNOWN, ST_STUCK: begin
          if (high) begin
            rel_cnt_next = rel_inc;
            if (rel_inc > cfg.unstuck_ticks) begin
              state_next   = ST_RELEASED;
              rel_cnt_next = '0;
              evt.recover  = 1'b1;
            end
          end else begin
            rel_cnt_next = '0;
          end
        end
        default: begin
          state_next = ST_UNKNOWN;
        end
      endcase
    end
  end

  always_comb begin
    unique case (state_next)
      ST_RELEASED: code_next = mkd_pkg::CODE_RELEASED;
      ST_PRESSED:  code_next = mkd_pkg::CODE_PRESSED;
      ST_STUCK:    code_next = mkd_pkg::CODE_STUCK;
      default:     code_next = mkd_pkg::CODE_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_UNKNOWN;
      press_cnt <= '0;
      rel_cnt   <= '0;
      hold_cnt  <= '0;
    end else if (tick) begin
      state     <= state_next;
      press_cnt <= press_cnt_next;
      rel_cnt   <= rel_cnt_next;
      hold_cnt  <= hold_cnt_next;
    end
  end

endmodule

### hdl/mkd_merge.sv
// Merge of lane events: suffix sums of count steps in key order and their maximum.
module mkd_merge #(
  parameter int unsigned NUM_KEYS = 8,
  parameter int unsigned SUM_W    = 5
) (
  input  mkd_pkg::lane_evt_t       evt [NUM_KEYS],
  output logic signed [SUM_W-1:0]  suf_all,
  output logic signed [SUM_W-1:0]  suf_max
);

  // A floored walk ends at max(start + total step, largest tail sum, zero);
  // tail sums start after each key, so the start value is not needed here.
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] step;
    acc  = '0;
    best = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (evt[k].to_stuck) begin
        step = SUM_W'(1);
      end else if (evt[k].recover) begin
        step = -SUM_W'(1);
      end else begin
        step = '0;
      end
      if (k > 0) begin
        acc = acc + step;
        if (acc > best) begin
          best = acc;
        end
      end else begin
        acc = acc + step;
      end
    end
    suf_all = acc;
    suf_max = best;
  end

endmodule

### hdl/multi_key_debounce_stuck_detect.sv
// Top level: multi-key debounce with stuck-key detection and a shared stuck count.
// Pipeline: two register stages (merge, then output); the result of an accepted item
// moves from the merge register into the output register when out_stall allows it.
// Throughput: one item per cycle while in_stall is low; every key lane and the merge take each accepted tick.
// A result held by out_stall still lets one more item enter the merge register.
// Reset (rst, synchronous): all keys unknown, counters zero, stuck count zero,
// registers back to press 5, release 5, stuck 6000, unstuck 200, hold-off 10.
module multi_key_debounce_stuck_detect #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mkd_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mkd_pkg::PIN_BITS-1:0]         pin_levels,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2*mkd_pkg::PACKED_KEYS-1:0]    key_status_packed,
  output logic [mkd_pkg::TOTAL_W-1:0]          stuck_count
);

  // Signed width of a step sum over all keys, and of the count update.
  localparam int unsigned SUM_W  = $clog2(NUM_KEYS + 1) + 1;
  localparam int unsigned CALC_W = mkd_pkg::TOTAL_W + 2;
  localparam int unsigned PACK_KEYS =
    (NUM_KEYS < mkd_pkg::PACKED_KEYS) ? NUM_KEYS : mkd_pkg::PACKED_KEYS;

  mkd_pkg::cfg_t               cfg;
  logic                        in_take;
  logic                        s1_load, out_load;
  logic [1:0]                  code [NUM_KEYS];
  mkd_pkg::lane_evt_t          evt [NUM_KEYS];
  logic [2*mkd_pkg::PACKED_KEYS-1:0] packed_next;
  logic signed [SUM_W-1:0]     suf_all, suf_max;

  // Merge register between the lanes and the output register.
  logic                        s1_valid;
  logic [2*mkd_pkg::PACKED_KEYS-1:0] s1_packed;
  logic signed [SUM_W-1:0]     s1_suf_all, s1_suf_max;

  logic [mkd_pkg::TOTAL_W-1:0] stuck_total, stuck_total_next;
  logic signed [CALC_W-1:0]    walk_end, tail_best;

  // ---------------------------------------------------------------------------
  // Configuration registers; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_ticks   <= mkd_pkg::PRESS_RST;
      cfg.release_ticks <= mkd_pkg::RELEASE_RST;
      cfg.stuck_ticks   <= mkd_pkg::STUCK_RST;
      cfg.unstuck_ticks <= mkd_pkg::UNSTUCK_RST;
      cfg.holdoff_ticks <= mkd_pkg::HOLDOFF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mkd_pkg::REG_PRESS:   cfg.press_ticks   <= cfg_data;
        mkd_pkg::REG_RELEASE: cfg.release_ticks <= cfg_data;
        mkd_pkg::REG_STUCK:   cfg.stuck_ticks   <= cfg_data;
        mkd_pkg::REG_UNSTUCK: cfg.unstuck_ticks <= cfg_data;
        mkd_pkg::REG_HOLDOFF: cfg.holdoff_ticks <= cfg_data[mkd_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the output register loads when empty or being taken; the
  // merge register loads when empty or moving on. Input is held only when both
  // stages are full and the output is stalled.
  // ---------------------------------------------------------------------------
  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_load;
  assign in_stall = !s1_load;
  assign in_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Key lanes: every key advances on an accepted item. Keys past the pin field
  // read as not pressed.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic high;
    if (k < mkd_pkg::PIN_BITS) begin : g_pin
      assign high = pin_levels[k];
    end else begin : g_nopin
      assign high = 1'b1;
    end
    mkd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .tick      (in_take),
      .high      (high),
      .code_next (code[k]),
      .evt       (evt[k])
    );
  end

  // Pack the reported keys; unreported slots stay zero.
  always_comb begin
    packed_next = '0;
    for (int k = 0; k < PACK_KEYS; k++) begin
      packed_next[2*k +: 2] = code[k];
    end
  end

  mkd_merge #(
    .NUM_KEYS (NUM_KEYS),
    .SUM_W    (SUM_W)
  ) u_merge (
    .evt     (evt),
    .suf_all (suf_all),
    .suf_max (suf_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_packed  <= packed_next;
      s1_suf_all <= suf_all;
      s1_suf_max <= suf_max;
    end
  end

  // ---------------------------------------------------------------------------
  // Stuck count: floored walk over the tick's steps in key order. The end is
  // the larger of the start plus the whole sum and the best tail sum (never
  // below zero). Saturate at the count's top, which the key count keeps clear.
  // ---------------------------------------------------------------------------
  always_comb begin
    walk_end  = CALC_W'(signed'({1'b0, stuck_total})) + CALC_W'(s1_suf_all);
    tail_best = CALC_W'(s1_suf_max);
    if (tail_best > walk_end) begin
      walk_end = tail_best;
    end
    if (walk_end > CALC_W'(signed'({1'b0, mkd_pkg::TOTAL_MAX}))) begin
      stuck_total_next = mkd_pkg::TOTAL_MAX;
    end else begin
      stuck_total_next = walk_end[mkd_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      stuck_total <= '0;
    end else if (out_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        stuck_total <= stuck_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      key_status_packed <= s1_packed;
    end
  end

  assign stuck_count = stuck_total;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // The count can never pass the number of keys.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    stuck_total <= mkd_pkg::TOTAL_W'(NUM_KEYS))
    else $error("stuck count above key count");

  // The count moves only when a merged tick reaches the output register.
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !(out_load && s1_valid) |=> $stable(stuck_total))
    else $error("stuck count moved without a tick");

  // Input is held back only with both stages full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input held with room in the pipeline");

  // The best tail sum of a merged tick is never below zero.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_suf_max >= 0))
    else $error("tail sum maximum below zero");

endmodule
